>>> hw/rtl/erp_pkg.sv
// Shared types, constants and codes for the ELF relocation patcher.
package erp_pkg;

    // Store depths and derived widths
    localparam int HI_PENDING_DEPTH = 32;
    localparam int VENEER_DEPTH     = 16;
    localparam int VENEER_BYTES     = 8;
    localparam int HI_AW = (HI_PENDING_DEPTH > 1) ? $clog2(HI_PENDING_DEPTH) : 1;
    localparam int HI_CW = $clog2(HI_PENDING_DEPTH + 1);
    localparam int VN_AW = (VENEER_DEPTH > 1) ? $clog2(VENEER_DEPTH) : 1;
    localparam int VN_CW = $clog2(VENEER_DEPTH + 1);
    localparam int HI_W  = 96;
    localparam int VN_W  = 64;

    // Configuration register indexes
    localparam logic [2:0] CFG_MACHINE      = 3'd0;
    localparam logic [2:0] CFG_RUNTIME_BASE = 3'd1;
    localparam logic [2:0] CFG_IMAGE_BASE   = 3'd2;
    localparam logic [2:0] CFG_DRAM_SIZE    = 3'd3;
    localparam logic [2:0] CFG_DRAM_USED    = 3'd4;

    typedef enum logic [1:0] {
        MACH_MIPS = 2'd0,
        MACH_M68K = 2'd1,
        MACH_SH   = 2'd2,
        MACH_ARM  = 2'd3
    } machine_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_UNDEF   = 3'd1,
        ST_RANGE   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_UNSUP   = 3'd4
    } status_t;

    // Relocation type codes
    localparam logic [7:0] MIPS_NONE   = 8'd0;
    localparam logic [7:0] MIPS_32     = 8'd2;
    localparam logic [7:0] MIPS_26     = 8'd4;
    localparam logic [7:0] MIPS_HI16   = 8'd5;
    localparam logic [7:0] MIPS_LO16   = 8'd6;
    localparam logic [7:0] SIMPLE_NONE = 8'd0;
    localparam logic [7:0] SIMPLE_32   = 8'd1;
    localparam logic [7:0] ARM_NONE    = 8'd0;
    localparam logic [7:0] ARM_V4BX    = 8'd40;
    localparam logic [7:0] ARM_ABS32   = 8'd2;
    localparam logic [7:0] ARM_PC24    = 8'd27;
    localparam logic [7:0] ARM_CALL    = 8'd28;
    localparam logic [7:0] ARM_JUMP24  = 8'd29;

    // Instruction field masks and veneer code
    localparam logic [31:0] J26_KEEP    = 32'hfc000000;
    localparam logic [31:0] J26_FIELD   = 32'h03ffffff;
    localparam logic [31:0] REGION_MASK = 32'hf0000000;
    localparam logic [31:0] B24_FWD_LIM = 32'h02000000;
    localparam logic [31:0] B24_BWD_LIM = 32'hfe000000;
    localparam logic [31:0] VENEER_LDR  = 32'he51ff004;
    localparam logic [31:0] B24_FIELD   = 32'h00ffffff;
    localparam logic [31:0] B24_KEEP    = 32'hff000000;
    localparam logic [31:0] HALF_ROUND  = 32'h00008000;

    typedef enum logic [1:0] {
        CLS_SINGLE,
        CLS_HI,
        CLS_LO,
        CLS_FAR
    } cls_t;

    typedef enum logic [2:0] {
        SEL_SINGLE,
        SEL_ERR,
        SEL_HI_WR,
        SEL_LO_WR,
        SEL_V0,
        SEL_V1,
        SEL_ARM_FIN
    } sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_EMIT_ONE,
        S_LO_RD,
        S_LO_CHK,
        S_LO_HI,
        S_VS_RD,
        S_VS_CHK,
        S_VNEW,
        S_V0,
        S_V1
    } state_t;

    typedef struct packed {
        logic load_in;
        logic push_hi;
        logic clr_pend;
        logic walk_init;
        logic walk_dec;
        logic rd_hi;
        logic vs_init;
        logic vs_inc;
        logic rd_vn;
        logic ven_alloc;
        logic ven_found;
        logic emit;
        sel_t sel;
        logic last;
    } cmd_t;

    typedef struct packed {
        cls_t cls;
        logic hi_full;
        logic pend_empty;
        logic walk_zero;
        logic hi_match;
        logic ven_empty;
        logic vs_match;
        logic vs_end;
        logic ven_ok;
        logic slot_free;
    } sts_t;

endpackage

>>> hw/rtl/erp_ram.sv
// Generic single-port-write, registered-read RAM.
module erp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/erp_ctrl.sv
// Sequencing state machine for the relocation patcher.
module erp_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  erp_pkg::sts_t sts,
    output erp_pkg::cmd_t cmd
);

    import erp_pkg::*;

    state_t state_reg, state_next;
    sel_t   sel_reg, sel_next;

    // Hold state and pending selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_SINGLE;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
        end
    end

    // Advance through decode, queue walk and veneer search
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cmd        = '0;
        cmd.sel    = SEL_SINGLE;
        in_stall   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (sts.cls)
                    CLS_SINGLE:
                    begin
                        sel_next   = SEL_SINGLE;
                        state_next = S_EMIT_ONE;
                    end
                    CLS_HI:
                    begin
                        cmd.push_hi = !sts.hi_full;
                        sel_next    = sts.hi_full ? SEL_ERR : SEL_SINGLE;
                        state_next  = S_EMIT_ONE;
                    end
                    CLS_LO:
                    begin
                        cmd.clr_pend = 1'b1;
                        if (sts.pend_empty)
                        begin
                            sel_next   = SEL_LO_WR;
                            state_next = S_EMIT_ONE;
                        end
                        else
                        begin
                            cmd.walk_init = 1'b1;
                            state_next    = S_LO_RD;
                        end
                    end
                    CLS_FAR:
                    begin
                        if (sts.ven_empty)
                        begin
                            state_next = S_VNEW;
                        end
                        else
                        begin
                            cmd.vs_init = 1'b1;
                            state_next  = S_VS_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_EMIT_ONE:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = sel_reg;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LO_RD:
            begin
                cmd.rd_hi  = 1'b1;
                state_next = S_LO_CHK;
            end
            S_LO_CHK:
            begin
                if (!sts.hi_match)
                begin
                    sel_next   = SEL_ERR;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    state_next = S_LO_HI;
                end
            end
            S_LO_HI:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.sel  = SEL_HI_WR;
                    if (sts.walk_zero)
                    begin
                        sel_next   = SEL_LO_WR;
                        state_next = S_EMIT_ONE;
                    end
                    else
                    begin
                        cmd.walk_dec = 1'b1;
                        state_next   = S_LO_RD;
                    end
                end
            end
            S_VS_RD:
            begin
                cmd.rd_vn  = 1'b1;
                state_next = S_VS_CHK;
            end
            S_VS_CHK:
            begin
                if (sts.vs_match)
                begin
                    cmd.ven_found = 1'b1;
                    sel_next      = SEL_ARM_FIN;
                    state_next    = S_EMIT_ONE;
                end
                else if (sts.vs_end)
                begin
                    state_next = S_VNEW;
                end
                else
                begin
                    cmd.vs_inc = 1'b1;
                    state_next = S_VS_RD;
                end
            end
            S_VNEW:
            begin
                if (!sts.ven_ok)
                begin
                    sel_next   = SEL_ERR;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    cmd.ven_alloc = 1'b1;
                    state_next    = S_V0;
                end
            end
            S_V0:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_V0;
                    state_next = S_V1;
                end
            end
            S_V1:
            begin
                if (sts.slot_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = SEL_V1;
                    sel_next   = SEL_ARM_FIN;
                    state_next = S_EMIT_ONE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hw/rtl/erp_dp.sv
// Datapath: configuration, item registers, pending and veneer stores, result register.
module erp_dp (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic [7:0]    command,
    input  logic          symbol_defined,
    input  logic [31:0]   symbol_value,
    input  logic [31:0]   place_address,
    input  logic [31:0]   image_address,
    input  logic [31:0]   current_word,
    input  erp_pkg::cmd_t cmd,
    output erp_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_stall,
    output logic          write_valid,
    output logic [31:0]   write_address,
    output logic [31:0]   write_data,
    output logic [2:0]    status,
    output logic          last
);

    import erp_pkg::*;

    // Configuration
    machine_t    machine_reg;
    logic [31:0] runtime_base_reg, image_base_reg, dram_size_reg, used_now_reg;

    // Item registers
    logic [7:0]  type_reg;
    logic        def_reg;
    logic [31:0] sym_reg, place_reg, img_reg, cw_reg;

    // Store control
    logic [HI_CW-1:0] pend_cnt_reg;
    logic [HI_AW-1:0] walk_reg;
    logic [VN_CW-1:0] ven_cnt_reg;
    logic [VN_AW-1:0] vs_reg;
    logic [31:0]      align_reg, vaddr_reg;

    // Result register
    logic        ov_reg, wv_reg, last_reg;
    logic [31:0] wa_reg, wd_reg;
    status_t     st_reg;

    logic [HI_W-1:0] hi_rd;
    logic [VN_W-1:0] vn_rd;
    logic [31:0]     hi_addr, hi_word, hi_sym, vn_tgt, vn_off;

    // Per-item decode outputs
    cls_t        cls;
    logic        sgl_wv;
    logic [31:0] sgl_wd;
    status_t     sgl_st;
    logic [31:0] addend4, arm_off, fin_off, addlo, hi_sum, lo_sum, align, align_end;
    logic        far;

    logic        res_wv;
    logic [31:0] res_wa, res_wd;
    status_t     res_st;

    // Pending HI16 store and veneer table
    erp_ram #(.WIDTH(HI_W), .DEPTH(HI_PENDING_DEPTH)) u_hi_ram (
        .clk   (clk),
        .we    (cmd.push_hi),
        .waddr (pend_cnt_reg[HI_AW-1:0]),
        .wdata ({img_reg, cw_reg, sym_reg}),
        .re    (cmd.rd_hi),
        .raddr (walk_reg),
        .rdata (hi_rd)
    );

    erp_ram #(.WIDTH(VN_W), .DEPTH(VENEER_DEPTH)) u_vn_ram (
        .clk   (clk),
        .we    (cmd.ven_alloc),
        .waddr (ven_cnt_reg[VN_AW-1:0]),
        .wdata ({sym_reg, align}),
        .re    (cmd.rd_vn),
        .raddr (vs_reg),
        .rdata (vn_rd)
    );

    assign hi_addr = hi_rd[95:64];
    assign hi_word = hi_rd[63:32];
    assign hi_sym  = hi_rd[31:0];
    assign vn_tgt  = vn_rd[63:32];
    assign vn_off  = vn_rd[31:0];

    // Shared arithmetic
    assign addend4   = {{6{cw_reg[23]}}, cw_reg[23:0], 2'b00};
    assign arm_off   = sym_reg - place_reg + addend4;
    assign fin_off   = vaddr_reg - place_reg + addend4;
    assign far       = arm_off[31] ? (arm_off <= B24_BWD_LIM) : (arm_off >= B24_FWD_LIM);
    assign addlo     = {{16{cw_reg[15]}}, cw_reg[15:0]};
    assign hi_sum    = {hi_word[15:0], 16'h0000} + addlo + sym_reg + HALF_ROUND;
    assign lo_sum    = sym_reg + addlo;
    assign align     = (used_now_reg + 32'd3) & ~32'd3;
    assign align_end = align + 32'(VENEER_BYTES);

    // Classify the item and form the one-result answers
    always_comb
    begin
        cls    = CLS_SINGLE;
        sgl_wv = 1'b0;
        sgl_wd = '0;
        sgl_st = ST_OK;
        unique case (machine_reg)
            MACH_MIPS:
            begin
                if (type_reg == MIPS_NONE)
                begin
                    sgl_st = ST_OK;
                end
                else if (type_reg != MIPS_32 && type_reg != MIPS_26 &&
                         type_reg != MIPS_HI16 && type_reg != MIPS_LO16)
                begin
                    sgl_st = ST_UNKNOWN;
                end
                else if (!def_reg)
                begin
                    sgl_st = ST_UNDEF;
                end
                else if (type_reg == MIPS_32)
                begin
                    sgl_wv = 1'b1;
                    sgl_wd = cw_reg + sym_reg;
                end
                else if (type_reg == MIPS_26)
                begin
                    if (sym_reg[1:0] != 2'b00 ||
                        (sym_reg & REGION_MASK) != ((place_reg + 32'd4) & REGION_MASK))
                    begin
                        sgl_st = ST_RANGE;
                    end
                    else
                    begin
                        sgl_wv = 1'b1;
                        sgl_wd = (cw_reg & J26_KEEP) | ((sym_reg >> 2) & J26_FIELD);
                    end
                end
                else if (type_reg == MIPS_HI16)
                begin
                    cls = CLS_HI;
                end
                else
                begin
                    cls = CLS_LO;
                end
            end
            MACH_M68K, MACH_SH:
            begin
                if (type_reg == SIMPLE_NONE)
                begin
                    sgl_st = ST_OK;
                end
                else if (type_reg != SIMPLE_32)
                begin
                    sgl_st = ST_UNKNOWN;
                end
                else if (!def_reg)
                begin
                    sgl_st = ST_UNDEF;
                end
                else
                begin
                    sgl_wv = 1'b1;
                    sgl_wd = cw_reg + sym_reg;
                end
            end
            MACH_ARM:
            begin
                if (type_reg == ARM_NONE || type_reg == ARM_V4BX)
                begin
                    sgl_st = ST_OK;
                end
                else if (type_reg != ARM_ABS32 && type_reg != ARM_PC24 &&
                         type_reg != ARM_CALL && type_reg != ARM_JUMP24)
                begin
                    sgl_st = ST_UNKNOWN;
                end
                else if (!def_reg)
                begin
                    sgl_st = ST_UNDEF;
                end
                else if (type_reg == ARM_ABS32)
                begin
                    sgl_wv = 1'b1;
                    sgl_wd = cw_reg + sym_reg;
                end
                else if (arm_off[1:0] != 2'b00)
                begin
                    sgl_st = ST_RANGE;
                end
                else if (far)
                begin
                    cls = CLS_FAR;
                end
                else
                begin
                    sgl_wv = 1'b1;
                    sgl_wd = (cw_reg & B24_KEEP) | ((arm_off >> 2) & B24_FIELD);
                end
            end
            default:
            begin
                sgl_st = ST_UNSUP;
            end
        endcase
    end

    // Select the result to present
    always_comb
    begin
        res_wv = 1'b1;
        res_wa = img_reg;
        res_wd = '0;
        res_st = ST_OK;
        unique case (cmd.sel)
            SEL_SINGLE:
            begin
                res_wv = sgl_wv;
                res_wa = sgl_wv ? img_reg : 32'd0;
                res_wd = sgl_wd;
                res_st = sgl_st;
            end
            SEL_ERR:
            begin
                res_wv = 1'b0;
                res_wa = '0;
                res_st = ST_RANGE;
            end
            SEL_HI_WR:
            begin
                res_wa = hi_addr;
                res_wd = {hi_word[31:16], hi_sum[31:16]};
            end
            SEL_LO_WR:
            begin
                res_wd = {cw_reg[31:16], lo_sum[15:0]};
            end
            SEL_V0:
            begin
                res_wa = image_base_reg + align_reg;
                res_wd = VENEER_LDR;
            end
            SEL_V1:
            begin
                res_wa = image_base_reg + align_reg + 32'd4;
                res_wd = sym_reg;
            end
            SEL_ARM_FIN:
            begin
                res_wd = (cw_reg & B24_KEEP) | ((fin_off >> 2) & B24_FIELD);
            end
            default:
            begin
                res_wv = 1'b0;
                res_wa = '0;
            end
        endcase
    end

    // Configuration writes and store counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            machine_reg      <= MACH_MIPS;
            runtime_base_reg <= '0;
            image_base_reg   <= '0;
            dram_size_reg    <= '0;
            used_now_reg     <= '0;
            pend_cnt_reg     <= '0;
            ven_cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MACHINE:      machine_reg      <= machine_t'(cfg_data[1:0]);
                    CFG_RUNTIME_BASE: runtime_base_reg <= cfg_data;
                    CFG_IMAGE_BASE:   image_base_reg   <= cfg_data;
                    CFG_DRAM_SIZE:    dram_size_reg    <= cfg_data;
                    CFG_DRAM_USED:    used_now_reg     <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.push_hi)
            begin
                pend_cnt_reg <= pend_cnt_reg + 1'b1;
            end
            else if (cmd.clr_pend)
            begin
                pend_cnt_reg <= '0;
            end
            if (cmd.ven_alloc)
            begin
                ven_cnt_reg  <= ven_cnt_reg + 1'b1;
                used_now_reg <= align_end;
            end
        end
    end

    // Item, walk and veneer working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            type_reg  <= command;
            def_reg   <= symbol_defined;
            sym_reg   <= symbol_value;
            place_reg <= place_address;
            img_reg   <= image_address;
            cw_reg    <= current_word;
        end
        if (cmd.walk_init)
        begin
            walk_reg <= HI_AW'(pend_cnt_reg - 1'b1);
        end
        else if (cmd.walk_dec)
        begin
            walk_reg <= walk_reg - 1'b1;
        end
        if (cmd.vs_init)
        begin
            vs_reg <= '0;
        end
        else if (cmd.vs_inc)
        begin
            vs_reg <= vs_reg + 1'b1;
        end
        if (cmd.ven_alloc)
        begin
            align_reg <= align;
            vaddr_reg <= runtime_base_reg + align;
        end
        else if (cmd.ven_found)
        begin
            vaddr_reg <= runtime_base_reg + vn_off;
        end
    end

    // Result register: load on emit, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            wv_reg   <= res_wv;
            wa_reg   <= res_wa;
            wd_reg   <= res_wd;
            st_reg   <= res_st;
            last_reg <= cmd.last;
        end
    end

    // Status toward the controller
    always_comb
    begin
        sts.cls        = cls;
        sts.hi_full    = pend_cnt_reg >= HI_CW'(HI_PENDING_DEPTH);
        sts.pend_empty = pend_cnt_reg == '0;
        sts.walk_zero  = walk_reg == '0;
        sts.hi_match   = hi_sym == sym_reg;
        sts.ven_empty  = ven_cnt_reg == '0;
        sts.vs_match   = vn_tgt == sym_reg;
        sts.vs_end     = (VN_CW'(vs_reg) + 1'b1) >= ven_cnt_reg;
        sts.ven_ok     = (align_end < dram_size_reg) &&
                         (ven_cnt_reg < VN_CW'(VENEER_DEPTH));
        sts.slot_free  = !ov_reg || !out_stall;
    end

    assign out_valid     = ov_reg;
    assign write_valid   = wv_reg;
    assign write_address = wa_reg;
    assign write_data    = wd_reg;
    assign status        = st_reg;
    assign last          = last_reg;

endmodule

>>> hw/rtl/elf_relocation_patcher_core.sv
// Top level of the ELF relocation patcher: controller plus datapath.
//
//  Channel   Handshake                 Payload
//  input     in_valid / in_stall       command, symbol_defined, symbol_value,
//                                      place_address, image_address, current_word
//  output    out_valid / out_stall     write_valid, write_address, write_data,
//                                      status, last
//  config    cfg_we                    cfg_index, cfg_data
//
// One item at a time. A plain relocation passes through decode and one emit state to its result.
// LO16 walks the queued HI16 entries and emits a write for each; each step reads the pending RAM once.
// ARM far branches search the veneer slots in turn and, if none matches, build a new veneer
// (room check and its two words).
// Reset clears the counters, the machine and DRAM registers; no clearing pass.
// A stalled result holds in the output register; the next item waits in the input.
module elf_relocation_patcher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  command,
    input  logic        symbol_defined,
    input  logic [31:0] symbol_value,
    input  logic [31:0] place_address,
    input  logic [31:0] image_address,
    input  logic [31:0] current_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_valid,
    output logic [31:0] write_address,
    output logic [31:0] write_data,
    output logic [2:0]  status,
    output logic        last
);

    import erp_pkg::*;

    cmd_t cmd;
    sts_t sts;

    erp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    erp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .command        (command),
        .symbol_defined (symbol_defined),
        .symbol_value   (symbol_value),
        .place_address  (place_address),
        .image_address  (image_address),
        .current_word   (current_word),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .write_valid    (write_valid),
        .write_address  (write_address),
        .write_data     (write_data),
        .status         (status),
        .last           (last)
    );

endmodule

>>> hw/rtl/erp_checker.sv
// Port-level checks for the relocation patcher, bound to the top level.
module erp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        write_valid,
    input logic [31:0] write_address,
    input logic [31:0] write_data,
    input logic [2:0]  status,
    input logic        last
);

    import erp_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // Stall input right after an item is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // Report a no-write result with cleared address and data
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_valid |-> write_address == 32'd0 && write_data == 32'd0)
        else $error("no-write result carries data");

    // End the item on any error
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last && !write_valid)
        else $error("error result not final");

    // Never report an unsupported machine
    a_no_unsup: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != ST_UNSUP)
        else $error("unsupported machine reported");

endmodule

bind elf_relocation_patcher_core erp_checker u_erp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .write_valid   (write_valid),
    .write_address (write_address),
    .write_data    (write_data),
    .status        (status),
    .last          (last)
);
